>>> hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB colour conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int IN_HUE_W    = 16;   // hue port, 1/64 degree units
    localparam int IN_FRAC_W   = 13;   // saturation / brightness ports
    localparam int CH_W        = 8;    // one colour channel
    localparam int HUE_W       = 15;   // hue after reduction, below 23040
    localparam int OFF_W       = 12;   // offset within a 60 degree sector
    localparam int SECTOR_SPAN = 3840; // 60 degrees in hue units

    localparam logic [IN_HUE_W-1:0] HUE_FULL   = IN_HUE_W'(6 * SECTOR_SPAN);
    localparam logic [IN_HUE_W-1:0] HUE_DOUBLE = IN_HUE_W'(12 * SECTOR_SPAN);
    localparam logic [OFF_W-1:0]    HUE_SECTOR = OFF_W'(SECTOR_SPAN);

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic    valid;
        t_sector sector;
    } t_ctrl;

    // width of a clamped Q0.F input: at most 1.0, never wider than the port
    function automatic int clamp_width(input int frac_bits);
        return (frac_bits + 1 < IN_FRAC_W) ? frac_bits + 1 : IN_FRAC_W;
    endfunction

endpackage

>>> hdl/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Front stages: hue reduction, input clamping, sector and weight selection.
// ----------------------------------------------------------------------------
module hsv2rgb_sector #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hsv2rgb_pkg::IN_HUE_W-1:0]    i_hue,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0]   i_saturation,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0]   i_brightness,
    output hsv2rgb_pkg::t_ctrl                  o_ctrl,
    output logic [hsv2rgb_pkg::OFF_W-1:0]       o_u,
    output logic [hsv2rgb_pkg::clamp_width(FRAC_BITS)-1:0] o_sat,
    output logic [hsv2rgb_pkg::clamp_width(FRAC_BITS)-1:0] o_bri,
    output logic [FRAC_BITS:0]                  o_nsat
);

    localparam int CW = hsv2rgb_pkg::clamp_width(FRAC_BITS);
    localparam int MW = (FRAC_BITS + 1 > hsv2rgb_pkg::IN_FRAC_W) ?
                        FRAC_BITS + 1 : hsv2rgb_pkg::IN_FRAC_W;
    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int SP = hsv2rgb_pkg::SECTOR_SPAN;
    localparam logic [MW-1:0]        ONE_M = MW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // stage 1
    logic                 r_vld1, n_vld1;
    logic [HW-1:0]        r_h, n_h;
    logic [CW-1:0]        r_sat1, n_sat1, r_bri1, n_bri1;
    logic [MW-1:0]        sat_m, bri_m;
    // stage 2
    hsv2rgb_pkg::t_ctrl   r_ctrl2, n_ctrl2;
    logic [hsv2rgb_pkg::OFF_W-1:0] r_u, n_u, off;
    logic [HW-1:0]        base;
    logic [CW-1:0]        r_sat2, r_bri2;
    logic [FRAC_BITS:0]   r_nsat, n_nsat;
    logic                 odd;

    assign sat_m = MW'(i_saturation);
    assign bri_m = MW'(i_brightness);

    always_comb begin
        n_vld1 = i_start;
        if (i_hue >= hsv2rgb_pkg::HUE_DOUBLE) begin
            n_h = HW'(i_hue - hsv2rgb_pkg::HUE_DOUBLE);
        end else if (i_hue >= hsv2rgb_pkg::HUE_FULL) begin
            n_h = HW'(i_hue - hsv2rgb_pkg::HUE_FULL);
        end else begin
            n_h = HW'(i_hue);
        end
        n_sat1 = (sat_m > ONE_M) ? ONE_M[CW-1:0] : sat_m[CW-1:0];
        n_bri1 = (bri_m > ONE_M) ? ONE_M[CW-1:0] : bri_m[CW-1:0];
    end

    // a hue exactly on a boundary belongs to the sector starting there
    always_comb begin
        priority if (r_h >= HW'(5 * SP)) begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_M_R;
            base           = HW'(5 * SP);
        end else if (r_h >= HW'(4 * SP)) begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_B_M;
            base           = HW'(4 * SP);
        end else if (r_h >= HW'(3 * SP)) begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_C_B;
            base           = HW'(3 * SP);
        end else if (r_h >= HW'(2 * SP)) begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_G_C;
            base           = HW'(2 * SP);
        end else if (r_h >= HW'(SP)) begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_Y_G;
            base           = HW'(SP);
        end else begin
            n_ctrl2.sector = hsv2rgb_pkg::SEC_R_Y;
            base           = '0;
        end
        n_ctrl2.valid = r_vld1;
        off = hsv2rgb_pkg::OFF_W'(r_h - base);
        odd = (n_ctrl2.sector == hsv2rgb_pkg::SEC_Y_G) ||
              (n_ctrl2.sector == hsv2rgb_pkg::SEC_C_B) ||
              (n_ctrl2.sector == hsv2rgb_pkg::SEC_M_R);
        // u is the distance of x below c, in hue units
        n_u    = odd ? off : hsv2rgb_pkg::HUE_SECTOR - off;
        n_nsat = ONE_F - (FRAC_BITS+1)'(r_sat1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1        <= 1'b0;
            r_ctrl2.valid <= 1'b0;
        end else begin
            r_vld1        <= n_vld1;
            r_ctrl2.valid <= n_ctrl2.valid;
        end
        r_ctrl2.sector <= n_ctrl2.sector;
    end

    always_ff @(posedge i_clk) begin
        r_h            <= n_h;
        r_sat1         <= n_sat1;
        r_bri1         <= n_bri1;
        r_u            <= n_u;
        r_sat2         <= r_sat1;
        r_bri2         <= r_bri1;
        r_nsat         <= n_nsat;
    end

    assign o_ctrl = r_ctrl2;
    assign o_u    = r_u;
    assign o_sat  = r_sat2;
    assign o_bri  = r_bri2;
    assign o_nsat = r_nsat;

`ifndef NO_ASSERTIONS
    a_hue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_h < HW'(6 * SP)))
        else $error("hue not reduced below 360 degrees");
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |=> (r_u <= hsv2rgb_pkg::HUE_SECTOR))
        else $error("sector weight out of range");
`endif

endmodule

>>> hdl/hsv2rgb_chroma.sv
// ----------------------------------------------------------------------------
// hsv2rgb_chroma
// Back stages: chroma products and the three rounded channel levels.
// ----------------------------------------------------------------------------
module hsv2rgb_chroma #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hsv2rgb_pkg::t_ctrl                  i_ctrl,
    input  logic [hsv2rgb_pkg::OFF_W-1:0]       i_u,
    input  logic [hsv2rgb_pkg::clamp_width(FRAC_BITS)-1:0] i_sat,
    input  logic [hsv2rgb_pkg::clamp_width(FRAC_BITS)-1:0] i_bri,
    input  logic [FRAC_BITS:0]                  i_nsat,
    output hsv2rgb_pkg::t_ctrl                  o_ctrl,
    output logic [hsv2rgb_pkg::CH_W-1:0]        o_top,
    output logic [hsv2rgb_pkg::CH_W-1:0]        o_mid,
    output logic [hsv2rgb_pkg::CH_W-1:0]        o_low
);

    localparam int CW  = hsv2rgb_pkg::clamp_width(FRAC_BITS);
    localparam int OW  = hsv2rgb_pkg::OFF_W;
    localparam int SUW = CW + OW;              // s * u
    localparam int VNW = CW + FRAC_BITS + 1;   // v * (1 - s)
    localparam int WW  = FRAC_BITS + 12;       // weight w, at most 3840 * 2^F
    localparam int VWW = CW + WW;              // v * w
    localparam int TW  = FRAC_BITS + 10;
    localparam int LW  = 2 * FRAC_BITS + 10;
    localparam int PW  = 2 * FRAC_BITS + 18;
    localparam int CHW = hsv2rgb_pkg::CH_W;
    localparam logic [WW-1:0] WBASE = WW'(hsv2rgb_pkg::SECTOR_SPAN) << FRAC_BITS;

    hsv2rgb_pkg::t_ctrl r_ctrl3, r_ctrl4, r_ctrl5, r_ctrl6;
    logic [SUW-1:0] r_su, n_su;
    logic [VNW-1:0] r_vn, n_vn;
    logic [CW-1:0]  r_bri3, r_bri4;
    logic [CHW-1:0] r_top3, r_top4, r_top5, r_top6, n_top;
    logic [WW-1:0]  r_w, n_w;
    logic [CHW-1:0] r_low4, r_low5, r_low6, n_low;
    logic [VWW-1:0] r_vw, n_vw;
    logic [CHW-1:0] r_mid6, n_mid;
    logic [TW-1:0]  top_sum;
    logic [LW-1:0]  low_sum;
    logic [PW-1:0]  mid_sum;

    // stage 3: products and the top level (v * 255, rounded)
    always_comb begin
        n_su    = SUW'(i_sat) * SUW'(i_u);
        n_vn    = VNW'(i_bri) * VNW'(i_nsat);
        top_sum = (TW'(i_bri) << 8) - TW'(i_bri) + (TW'(1) << (FRAC_BITS - 1));
        n_top   = top_sum[FRAC_BITS +: CHW];
    end

    // stage 4: w = 3840 - s*u scaled, and the low level m * 255
    always_comb begin
        n_w     = WBASE - WW'(r_su);
        low_sum = (LW'(r_vn) << 8) - LW'(r_vn) + (LW'(1) << (2 * FRAC_BITS - 1));
        n_low   = low_sum[2 * FRAC_BITS +: CHW];
    end

    // stage 5: v * w
    assign n_vw = VWW'(r_bri4) * VWW'(r_w);

    // stage 6: 255/3840 reduces to 17/256 on the common factor 15
    always_comb begin
        mid_sum = (PW'(r_vw) << 4) + PW'(r_vw) + (PW'(1) << (2 * FRAC_BITS + 7));
        n_mid   = mid_sum[2 * FRAC_BITS + 8 +: CHW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl3.valid <= 1'b0;
            r_ctrl4.valid <= 1'b0;
            r_ctrl5.valid <= 1'b0;
            r_ctrl6.valid <= 1'b0;
        end else begin
            r_ctrl3.valid <= i_ctrl.valid;
            r_ctrl4.valid <= r_ctrl3.valid;
            r_ctrl5.valid <= r_ctrl4.valid;
            r_ctrl6.valid <= r_ctrl5.valid;
        end
        r_ctrl3.sector <= i_ctrl.sector;
        r_ctrl4.sector <= r_ctrl3.sector;
        r_ctrl5.sector <= r_ctrl4.sector;
        r_ctrl6.sector <= r_ctrl5.sector;
    end

    always_ff @(posedge i_clk) begin
        r_su   <= n_su;
        r_vn   <= n_vn;
        r_bri3 <= i_bri;
        r_top3 <= n_top;
        r_w    <= n_w;
        r_bri4 <= r_bri3;
        r_top4 <= r_top3;
        r_low4 <= n_low;
        r_vw   <= n_vw;
        r_top5 <= r_top4;
        r_low5 <= r_low4;
        r_mid6 <= n_mid;
        r_top6 <= r_top5;
        r_low6 <= r_low5;
    end

    assign o_ctrl = r_ctrl6;
    assign o_top  = r_top6;
    assign o_mid  = r_mid6;
    assign o_low  = r_low6;

`ifndef NO_ASSERTIONS
    a_level_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl6.valid |-> ((r_low6 <= r_mid6) && (r_mid6 <= r_top6)))
        else $error("channel levels out of order");
`endif

endmodule

>>> hdl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to 8-bit RGB colour conversion, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: i_hue (1/64 degree), i_saturation and i_brightness (Q0.F,
//   values above 1.0 clamp). A beat is taken at each clock edge where
//   i_start is high and o_busy is low. o_busy is low whenever reset is
//   released, so a new colour may enter on every clock.
//   Result beat: o_red, o_green, o_blue with o_valid high for one cycle.
//   Pipeline: a colour passes seven register stages, the first loaded at
//   the taking edge: reduce/clamp, sector, products, weight and low
//   level, v*w product, mid level, channel map.
//   Throughput: one colour per clock; the v*w multiplier stage sets the
//   critical path.
//   Reset (synchronous, active low) clears every valid bit, so nothing in
//   flight is delivered; o_busy is high while reset is held.
//   The receiver cannot stall: each result is presented for one cycle only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [hsv2rgb_pkg::IN_HUE_W-1:0]  i_hue,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0] i_brightness,
    output logic                              o_valid,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_blue
);

    localparam int CW  = hsv2rgb_pkg::clamp_width(FRAC_BITS);
    localparam int CHW = hsv2rgb_pkg::CH_W;

    hsv2rgb_pkg::t_ctrl           sec_ctrl, chr_ctrl;
    logic [hsv2rgb_pkg::OFF_W-1:0] sec_u;
    logic [CW-1:0]                sec_sat, sec_bri;
    logic [FRAC_BITS:0]           sec_nsat;
    logic [CHW-1:0]               lvl_top, lvl_mid, lvl_low;
    logic                         accept;
    logic                         r_valid;
    logic [CHW-1:0]               r_red, r_green, r_blue, n_red, n_green, n_blue;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    hsv2rgb_sector #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sector (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_ctrl      (sec_ctrl),
        .o_u         (sec_u),
        .o_sat       (sec_sat),
        .o_bri       (sec_bri),
        .o_nsat      (sec_nsat)
    );

    hsv2rgb_chroma #(
        .FRAC_BITS(FRAC_BITS)
    ) u_chroma (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (sec_ctrl),
        .i_u    (sec_u),
        .i_sat  (sec_sat),
        .i_bri  (sec_bri),
        .i_nsat (sec_nsat),
        .o_ctrl (chr_ctrl),
        .o_top  (lvl_top),
        .o_mid  (lvl_mid),
        .o_low  (lvl_low)
    );

    // place c, x and 0 (plus m) across the channels by sector
    always_comb begin
        unique case (chr_ctrl.sector)
            hsv2rgb_pkg::SEC_R_Y: begin
                n_red = lvl_top; n_green = lvl_mid; n_blue = lvl_low;
            end
            hsv2rgb_pkg::SEC_Y_G: begin
                n_red = lvl_mid; n_green = lvl_top; n_blue = lvl_low;
            end
            hsv2rgb_pkg::SEC_G_C: begin
                n_red = lvl_low; n_green = lvl_top; n_blue = lvl_mid;
            end
            hsv2rgb_pkg::SEC_C_B: begin
                n_red = lvl_low; n_green = lvl_mid; n_blue = lvl_top;
            end
            hsv2rgb_pkg::SEC_B_M: begin
                n_red = lvl_mid; n_green = lvl_low; n_blue = lvl_top;
            end
            default: begin
                n_red = lvl_top; n_green = lvl_low; n_blue = lvl_mid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chr_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
    a_max_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_red >= o_green) && (o_red >= o_blue)) ||
                     ((o_green >= o_red) && (o_green >= o_blue)) ||
                     ((o_blue >= o_red) && (o_blue >= o_green))))
        else $error("no channel carries the top level");
    a_no_accept_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> o_busy)
        else $error("beat taken during reset");
`endif

endmodule

>>> test/hsv_to_rgb_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Watches the input and result channels of the HSV to RGB converter. It works
// out the RGB value of every colour taken, queues it, and compares each result
// beat field by field with the oldest queued colour.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [hsv2rgb_pkg::IN_HUE_W-1:0]  i_hue,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::IN_FRAC_W-1:0] i_brightness,
    input  logic                              i_valid,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      i_red,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      i_green,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      i_blue,
    output int                                o_pending,
    output int                                o_fail_count
);

    localparam int MAX_REPORTS = 10;
    localparam int SPAN        = hsv2rgb_pkg::SECTOR_SPAN;

    typedef struct packed {
        logic [hsv2rgb_pkg::CH_W-1:0] red;
        logic [hsv2rgb_pkg::CH_W-1:0] green;
        logic [hsv2rgb_pkg::CH_W-1:0] blue;
    } t_rgb;

    t_rgb rgb_due_q[$];
    int   mismatch_cnt;

    // (n * 255 + D/2) / D with D = 2^(2F) * 3840: the channel level rounded half up
    function automatic longint unsigned level_to_channel(input longint unsigned num);
        longint unsigned den;
        den = (64'd1 << (2 * FRAC_BITS)) * SPAN;
        return (num * 255 + den / 2) / den;
    endfunction

    function automatic t_rgb hsv_to_rgb_predict(
        input logic [hsv2rgb_pkg::IN_HUE_W-1:0]  hue,
        input logic [hsv2rgb_pkg::IN_FRAC_W-1:0] sat,
        input logic [hsv2rgb_pkg::IN_FRAC_W-1:0] bri
    );
        longint unsigned      one, h, s, v, off, wgt, vs, c_num, x_num, m_num;
        longint unsigned      top, mid, low;
        hsv2rgb_pkg::t_sector sector;
        t_rgb                 rgb;
        one = 64'd1 << FRAC_BITS;
        h   = longint'(hue) % (6 * SPAN);
        s   = (sat > one) ? one : sat;
        v   = (bri > one) ? one : bri;
        sector = hsv2rgb_pkg::t_sector'(3'(h / SPAN));
        off    = h % SPAN;
        // falling edge of the hue ramp in odd sectors
        wgt    = (h / SPAN) % 2 == 1 ? SPAN - off : off;
        vs     = v * s;
        c_num  = vs * SPAN;
        x_num  = vs * wgt;
        m_num  = v * one * SPAN - c_num;
        top = level_to_channel(c_num + m_num);
        mid = level_to_channel(x_num + m_num);
        low = level_to_channel(m_num);
        case (sector)
            hsv2rgb_pkg::SEC_R_Y: rgb = '{top[7:0], mid[7:0], low[7:0]};
            hsv2rgb_pkg::SEC_Y_G: rgb = '{mid[7:0], top[7:0], low[7:0]};
            hsv2rgb_pkg::SEC_G_C: rgb = '{low[7:0], top[7:0], mid[7:0]};
            hsv2rgb_pkg::SEC_C_B: rgb = '{low[7:0], mid[7:0], top[7:0]};
            hsv2rgb_pkg::SEC_B_M: rgb = '{mid[7:0], low[7:0], top[7:0]};
            default:              rgb = '{top[7:0], low[7:0], mid[7:0]};
        endcase
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        if (i_rst_n) begin
            got = '{i_red, i_green, i_blue};
            if (i_valid) begin
                if (rgb_due_q.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("ERROR: result beat with none due: r=%0d g=%0d b=%0d",
                                 i_red, i_green, i_blue);
                end else begin
                    want = rgb_due_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"ERROR: rgb mismatch: exp r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            if (i_start && !i_busy)
                rgb_due_q.push_back(hsv_to_rgb_predict(i_hue, i_saturation, i_brightness));
        end
        o_pending    <= rgb_due_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

>>> test/tb_hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Drives colours into the HSV to RGB converter: a directed set covering the
// hue sectors and their edges, hue wrap, clamping and black/white, then random
// colours with bursts of idle cycles. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_unit;

    localparam int FRAC_BITS   = 12;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HUE_W       = hsv2rgb_pkg::IN_HUE_W;
    localparam int FRAC_W      = hsv2rgb_pkg::IN_FRAC_W;
    localparam int SPAN        = hsv2rgb_pkg::SECTOR_SPAN;
    localparam int RAND_BEATS  = 1100;
    localparam int CALM_BEATS  = 150;    // tail of the run with no idling
    localparam int DRAIN_WAIT  = 16;     // pipeline is seven stages deep
    localparam int CYCLE_LIMIT = 200000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic [HUE_W-1:0]             i_hue = '0;
    logic [FRAC_W-1:0]            i_saturation = '0;
    logic [FRAC_W-1:0]            i_brightness = '0;
    logic                         o_busy;
    logic                         o_valid;
    logic [hsv2rgb_pkg::CH_W-1:0] o_red;
    logic [hsv2rgb_pkg::CH_W-1:0] o_green;
    logic [hsv2rgb_pkg::CH_W-1:0] o_blue;
    int                           pending;
    int                           fail_count;
    int                           cycle_cnt = 0;
    bit                           bursty = 1'b1;

    always #5 i_clk = ~i_clk;

    hsv_to_rgb_converter_unit #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_to_rgb_converter_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_valid      (o_valid),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // optional idle burst, then one beat held until taken
    task automatic send_colour(input int hue, input int sat, input int bri, input bit may_idle);
        bit taken;
        if (may_idle && bursty && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_hue        <= HUE_W'(hue);
        i_saturation <= FRAC_W'(sat);
        i_brightness <= FRAC_W'(bri);
        do begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic int rand_fraction();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom_range(ONE + 1, (1 << FRAC_W) - 1);   // clamps
        else if (pick == 1)
            return ($urandom_range(0, 1) == 1) ? ONE : 0;
        return $urandom_range(0, ONE);
    endfunction

    function automatic int rand_hue();
        int pick;
        int edge_hue;
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            // near a sector edge, possibly above one turn
            edge_hue = $urandom_range(0, 16) * SPAN + $urandom_range(0, 4) - 2;
            if (edge_hue < 0)
                edge_hue = 0;
            if (edge_hue > (1 << HUE_W) - 1)
                edge_hue = (1 << HUE_W) - 1;
            return edge_hue;
        end else if (pick < 6) begin
            return $urandom_range(0, 6 * SPAN - 1);
        end
        return $urandom_range(0, (1 << HUE_W) - 1);
    endfunction

    initial begin
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector starts and edges, hue wrap, grey axis, clamping
        send_colour(0,     ONE,  ONE,  1'b1);
        send_colour(3839,  ONE,  ONE,  1'b1);
        send_colour(3840,  ONE,  ONE,  1'b1);
        send_colour(7680,  ONE,  ONE,  1'b1);
        send_colour(11520, ONE,  ONE,  1'b1);
        send_colour(15360, ONE,  ONE,  1'b1);
        send_colour(19200, ONE,  ONE,  1'b1);
        send_colour(23039, ONE,  ONE,  1'b1);
        send_colour(23040, ONE,  ONE,  1'b1);
        send_colour(65535, ONE,  ONE,  1'b1);
        send_colour(1920,  ONE,  ONE,  1'b1);
        send_colour(5760,  2048, ONE,  1'b1);
        send_colour(0,     0,    ONE,  1'b1);
        send_colour(9000,  0,    0,    1'b1);
        send_colour(13000, ONE,  0,    1'b1);
        send_colour(17000, 8191, 8191, 1'b1);
        send_colour(21000, 4097, 2048, 1'b1);
        send_colour(2500,  2048, 4097, 1'b1);
        send_colour(46080, ONE,  2048, 1'b1);
        send_colour(46079, 1,    1,    1'b1);
        send_colour(26880, 4095, 4095, 1'b1);
        send_colour(100,   1,    ONE,  1'b1);
        send_colour(12000, 3000, 1234, 1'b1);
        send_colour(30000, 8191, 0,    1'b1);
        send_colour(0,     ONE,  1,    1'b1);

        for (n = 0; n < RAND_BEATS; n++) begin
            // alternate stretches with and without idle bursts
            if (n % 50 == 0)
                bursty = ($urandom_range(0, 2) != 0);
            send_colour(rand_hue(), rand_fraction(), rand_fraction(),
                        n < RAND_BEATS - CALM_BEATS);
        end
        i_start <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
